// ----- rtl/core/pof_pkg.sv -----
// Package: shared constants and types for the PCM overlap framer.
`timescale 1ns / 1ps
package pof_pkg;
  localparam int MaxChannels    = 8;
  localparam int MaxFrameLength = 1024;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_EOS  = 2'd2;
  localparam logic [1:0] CMD_NOP  = 2'd3;

  localparam logic [1:0] CFG_CHANNELS = 2'd0;
  localparam logic [1:0] CFG_BITS     = 2'd1;
  localparam logic [1:0] CFG_LENGTH   = 2'd2;
  localparam logic [1:0] CFG_HOP      = 2'd3;

  localparam logic [6:0] BITS_16 = 7'd16;
  localparam logic [6:0] BITS_24 = 7'd24;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  data_byte;
    logic [2:0]  channel;
    logic [9:0]  column;
  } pof_in_t;

  typedef struct packed {
    logic signed [23:0] sample;
    logic               frame_ready;
    logic [15:0]        frame_count;
    logic               not_eof;
    logic               format_error;
  } pof_out_t;
endpackage

// ----- rtl/core/pof_if.sv -----
// Interfaces: valid/ready channels carrying input and result beats.
`timescale 1ns / 1ps
interface pof_in_if;
  logic              valid;
  logic              ready;
  pof_pkg::pof_in_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pof_out_if;
  logic              valid;
  logic              ready;
  pof_pkg::pof_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/pof_ring.sv -----
// Sample ring memory: one write port, one registered read port.
`timescale 1ns / 1ps
module pof_ring #(
  parameter int AW = 14
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [23:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [23:0]   rd_data
);
  logic [23:0] mem [2**AW];
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule

// ----- rtl/core/pcm_overlap_framer_unit.sv -----
// Top level: PCM byte assembler, frame bookkeeping and sample ring read-out.
// Usage:
//   in channel: one beat per command (push byte, read element, end of stream, no-op).
//   out channel: exactly one result beat per input beat, in order.
//   cfg port: write enable, index, data; write only while idle.
// Path: stage 1 registers the beat with its ring read, stage 2 the result.
//   Throughput: one beat per cycle unless the receiver stalls, limited by
//   the single ring read and write ports, each used at most once per beat.
// A read accepted right after a push to the same ring entry sees the new value,
//   as the write lands at the edge that accepts the push, before the read.
// Reset (synchronous rst_n low) clears counters, flags and configuration to
//   defaults; the ring holds garbage until written, which no read can see
//   before a frame is complete.
// When the receiver stalls, the pipeline holds; a two-entry output buffer
//   keeps in_ready high until both stages are occupied.
`timescale 1ns / 1ps
module pcm_overlap_framer_unit #(
  parameter int MAX_CHANNELS     = pof_pkg::MaxChannels,
  parameter int MAX_FRAME_LENGTH = pof_pkg::MaxFrameLength
) (
  input  logic        clk,
  input  logic        rst_n,
  pof_in_if.sink      in_ch,
  pof_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import pof_pkg::*;

  localparam int RD  = 2 * MAX_FRAME_LENGTH;
  localparam int SW  = $clog2(RD);
  localparam int CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int AW  = SW + CW;

  logic [3:0]  chans_cfg_r;
  logic [6:0]  bits_r;
  logic [10:0] len_cfg_r;
  logic [12:0] hop_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chans_cfg_r <= 4'd1;
      bits_r      <= BITS_16;
      len_cfg_r   <= 11'd512;
      hop_cfg_r   <= 13'd160;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHANNELS: chans_cfg_r <= cfg_data[3:0];
        CFG_BITS:     bits_r      <= cfg_data[6:0];
        CFG_LENGTH:   len_cfg_r   <= cfg_data[10:0];
        CFG_HOP:      hop_cfg_r   <= cfg_data;
        default:      ;
      endcase
    end
  end

  logic [6:0]  chans;
  logic [13:0] len;
  logic [13:0] hop;
  logic [13:0] span;
  logic        fmt_bad;
  always_comb begin
    chans = (chans_cfg_r == 4'd0) ? 7'd1 :
            ({3'd0, chans_cfg_r} > 7'(MAX_CHANNELS)) ? 7'(MAX_CHANNELS) : {3'd0, chans_cfg_r};
    len = (len_cfg_r == 11'd0) ? 14'd1 :
          ({3'd0, len_cfg_r} > 14'(MAX_FRAME_LENGTH)) ? 14'(MAX_FRAME_LENGTH) :
          {3'd0, len_cfg_r};
    hop  = (hop_cfg_r == 13'd0) ? 14'd1 : {1'b0, hop_cfg_r};
    span = (hop > len) ? hop : len;
    fmt_bad = (bits_r != BITS_16) && (bits_r != BITS_24);
  end

  // Pipeline: stage 1 holds the command after ring access, stage 2 the result.
  logic     s1_v_r, s2_v_r;
  pof_out_t s1_r, s2_r;
  logic     s1_rd_r;
  logic [23:0] rd_data;

  assign in_ch.ready = !s1_v_r || !s2_v_r || out_ch.ready;
  logic acc;
  assign acc = in_ch.valid && in_ch.ready;

  logic [23:0] asm_r;
  logic [1:0]  bidx_r;
  logic [CW-1:0] cidx_r;
  logic [31:0] pos_r, nfe_r;
  logic [15:0] done_r;
  logic        eos_r, rdy_r;
  logic [SW-1:0] wslot_r, base_r;

  pof_in_t in_p;
  assign in_p = in_ch.payload;

  logic        samp_ok;
  logic [23:0] samp;
  logic [1:0]  bidx_nxt;
  logic [23:0] asm_nxt;
  logic [31:0] start, target, pos_inc;
  logic        in_win, last_ch, wr_en, fin;
  logic [CW-1:0] cur_ch;
  logic [1:0]  nb;
  logic [SW-1:0] wslot_inc;

  always_comb begin
    nb = (bits_r == BITS_24) ? 2'd3 : 2'd2;
    bidx_nxt = (bidx_r > 2'd2) ? 2'd0 : bidx_r;
    asm_nxt  = asm_r | ({16'd0, in_p.data_byte} << (5'(bidx_nxt) * 5'd8));
    bidx_nxt = bidx_nxt + 2'd1;
    samp_ok  = acc && in_p.cmd == CMD_PUSH && !fmt_bad && !eos_r && bidx_nxt >= nb;
    samp = (nb == 2'd2) ? {{8{asm_nxt[15]}}, asm_nxt[15:0]} : asm_nxt;
    start  = rdy_r ? nfe_r - {18'd0, span} : 32'd0;
    target = rdy_r ? nfe_r : {18'd0, len};
    in_win = (pos_r - start) < {18'd0, len};
    cur_ch = ({{(7-CW){1'b0}}, cidx_r} >= chans) ? '0 : cidx_r;
    last_ch = ({{(7-CW){1'b0}}, cur_ch} + 7'd1) >= chans;
    wr_en  = samp_ok && in_win;
    pos_inc = pos_r + 32'd1;
    wslot_inc = wslot_r + (in_win ? SW'(1) : SW'(0));
    fin = samp_ok && last_ch && !(pos_inc - target >= 32'h8000_0000);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asm_r <= '0; bidx_r <= '0; cidx_r <= '0; pos_r <= '0; nfe_r <= '0;
      done_r <= '0; eos_r <= 1'b0; rdy_r <= 1'b0; wslot_r <= '0; base_r <= '0;
    end else if (acc) begin
      if (in_p.cmd == CMD_EOS) eos_r <= 1'b1;
      if (in_p.cmd == CMD_PUSH && !fmt_bad && !eos_r) begin
        if (bidx_nxt >= nb) begin
          asm_r <= '0; bidx_r <= '0;
          if (last_ch) begin
            cidx_r  <= '0;
            pos_r   <= pos_inc;
            wslot_r <= wslot_inc;
            if (fin) begin
              done_r <= done_r + 16'd1;
              rdy_r  <= 1'b1;
              base_r <= wslot_inc - len[SW-1:0];
              nfe_r  <= pos_inc + {18'd0, hop};
            end
          end else begin
            cidx_r <= cur_ch + CW'(1);
          end
        end else begin
          asm_r <= asm_nxt; bidx_r <= bidx_nxt;
        end
      end
    end
  end

  logic rd_ok;
  logic [AW-1:0] rd_addr;
  assign rd_ok = acc && in_p.cmd == CMD_READ && rdy_r && !eos_r && !fmt_bad &&
                 ({4'd0, in_p.channel} < chans) && ({4'd0, in_p.column} < len);
  assign rd_addr = {in_p.channel[CW-1:0], base_r + SW'(in_p.column)};

  pof_ring #(.AW(AW)) u_ring (
    .clk(clk), .wr_en(wr_en), .wr_addr({cur_ch, wslot_r}), .wr_data(samp),
    .rd_en(rd_ok), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  logic rdy_now, eos_now;
  logic [15:0] done_now;
  assign rdy_now  = rdy_r  | fin;
  assign done_now = fin ? done_r + 16'd1 : done_r;
  assign eos_now  = eos_r | (acc && in_p.cmd == CMD_EOS);

  // Stage 1 must be able to move into stage 2 whenever a new beat is taken.
  logic s1_go;
  assign s1_go = s1_v_r && (!s2_v_r || out_ch.ready);

  pof_out_t s2_nxt;
  always_comb begin
    s2_nxt        = s1_r;
    s2_nxt.sample = s1_rd_r ? rd_data : 24'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0; s2_v_r <= 1'b0; s1_rd_r <= 1'b0;
    end else begin
      if (s1_go) begin
        s2_v_r <= 1'b1;
        s2_r   <= s2_nxt;
      end else if (out_ch.ready) begin
        s2_v_r <= 1'b0;
      end
      if (acc) begin
        s1_v_r  <= 1'b1;
        s1_rd_r <= rd_ok;
        s1_r    <= '{sample: 24'd0, frame_ready: rdy_now, frame_count: done_now,
                     not_eof: !eos_now, format_error: fmt_bad};
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid   = s2_v_r;
  assign out_ch.payload = s2_r;
endmodule

// ----- rtl/core/pof_checker.sv -----
// Checker: port-level properties of the framer, bound to the top level.
`timescale 1ns / 1ps
module pof_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] frame_count,
  input logic        frame_ready,
  input logic        not_eof
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_count != 16'd0 |-> frame_ready) else $error("ready flag");
  a_eof: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready ##1 out_valid && $past(!not_eof) |-> !not_eof)
    else $error("eof cleared");
endmodule

bind pcm_overlap_framer_unit pof_port_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .frame_count(out_ch.payload.frame_count), .frame_ready(out_ch.payload.frame_ready),
  .not_eof(out_ch.payload.not_eof)
);
